@@ src/mxiu_pkg.sv @@
// ----------------------------------------------------------------------------
// MIPS exception and interrupt unit package
// Command codes, register bit positions, exception vectors and the request
// structures that travel from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mxiu_pkg;

    localparam int unsigned CMD_W   = 4;
    localparam int unsigned LINE_W  = 3;
    localparam int unsigned NLINES  = 8;
    localparam int unsigned CODE_W  = 5;
    localparam int unsigned XLEN    = 64;
    localparam int unsigned REG_W   = 32;
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = 1;
    localparam int unsigned QCNT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_LINE     = 4'd0,
        CMD_CLR_LINE     = 4'd1,
        CMD_POLL         = 4'd2,
        CMD_RAISE        = 4'd3,
        CMD_COP_UNUSABLE = 4'd4,
        CMD_ERET         = 4'd5,
        CMD_WR_STATUS    = 4'd6,
        CMD_WR_CAUSE     = 4'd7,
        CMD_WR_EPC       = 4'd8,
        CMD_WR_ERROR_EPC = 4'd9
    } t_cmd;

    localparam logic [CODE_W-1:0] EXC_INT  = 5'd0;
    localparam logic [CODE_W-1:0] EXC_TLBL = 5'd2;
    localparam logic [CODE_W-1:0] EXC_TLBS = 5'd3;
    localparam logic [CODE_W-1:0] EXC_CPU  = 5'd11;

    // Status bits.
    localparam int unsigned ST_IE    = 0;
    localparam int unsigned ST_EXL   = 1;
    localparam int unsigned ST_ERL   = 2;
    localparam int unsigned ST_IM_LO = 8;
    localparam int unsigned ST_IM_HI = 15;
    localparam int unsigned ST_BEV   = 22;

    // Cause bits.
    localparam int unsigned CA_EXC_LO = 2;
    localparam int unsigned CA_EXC_HI = 6;
    localparam int unsigned CA_IP_LO  = 8;
    localparam int unsigned CA_IP_HI  = 15;
    localparam int unsigned CA_IV     = 23;
    localparam int unsigned CA_CE_LO  = 28;
    localparam int unsigned CA_CE_HI  = 29;
    localparam int unsigned CA_BD     = 31;

    localparam logic [REG_W-1:0] STATUS_RST = 32'h0040_0000;
    localparam logic [1:0]       CE_COP1    = 2'b01;

    localparam logic [XLEN-1:0] VEC_BEV_GEN = 64'hffff_ffff_bfc0_0380;
    localparam logic [XLEN-1:0] VEC_BEV_TLB = 64'hffff_ffff_bfc0_0200;
    localparam logic [XLEN-1:0] VEC_BEV_INT = 64'hffff_ffff_bfc0_0400;
    localparam logic [XLEN-1:0] VEC_GEN     = 64'hffff_ffff_8000_0180;
    localparam logic [XLEN-1:0] VEC_TLB     = 64'hffff_ffff_8000_0000;
    localparam logic [XLEN-1:0] VEC_INT     = 64'hffff_ffff_8000_0200;

    // One decoded request. value carries the PC for exception entry and the
    // write data for register writes.
    typedef struct packed {
        logic              set_line;
        logic              clr_line;
        logic              poll;
        logic              raise;
        logic              cpu;
        logic              eret;
        logic              wr_status;
        logic              wr_cause;
        logic              wr_epc;
        logic              wr_error_epc;
        logic [NLINES-1:0] line_mask;
        logic [CODE_W-1:0] code;
        logic              bd;
        logic [XLEN-1:0]   value;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_push;

    typedef struct packed {
        logic valid;
        logic full;
        t_op  op;
    } t_q_out;

endpackage

`default_nettype wire

@@ src/mxiu_if.sv @@
// ----------------------------------------------------------------------------
// MIPS exception and interrupt unit channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface mxiu_req_if;
    logic                          valid;
    logic                          ready;
    logic [mxiu_pkg::CMD_W-1:0]    cmd;
    logic [mxiu_pkg::LINE_W-1:0]   irq_line;
    logic [mxiu_pkg::CODE_W-1:0]   trap_code;
    logic                          bd_slot;
    logic [mxiu_pkg::XLEN-1:0]     current_pc;
    logic [mxiu_pkg::XLEN-1:0]     write_data;

    modport source (output valid, cmd, irq_line, trap_code, bd_slot, current_pc, write_data,
                    input ready);
    modport sink (input valid, cmd, irq_line, trap_code, bd_slot, current_pc, write_data,
                  output ready);
endinterface

interface mxiu_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          redirect;
    logic [mxiu_pkg::XLEN-1:0]     next_pc;
    logic [mxiu_pkg::REG_W-1:0]    status_now;
    logic [mxiu_pkg::REG_W-1:0]    cause_now;
    logic [mxiu_pkg::XLEN-1:0]     epc_now;
    logic                          pending_now;
    logic                          ll_clear;

    modport source (output valid, redirect, next_pc, status_now, cause_now, epc_now,
                    pending_now, ll_clear, input ready);
    modport sink (input valid, redirect, next_pc, status_now, cause_now, epc_now,
                  pending_now, ll_clear, output ready);
endinterface

`default_nettype wire

@@ src/mxiu_front.sv @@
// ----------------------------------------------------------------------------
// MIPS exception and interrupt unit front end
// Accepts requests and classifies them into decoded operations for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mxiu_front (
    mxiu_req_if.sink       i_req,
    input  logic           i_q_full,
    output mxiu_pkg::t_push o_push
);
    import mxiu_pkg::*;

    t_op w_op;

    assign i_req.ready = !i_q_full;

    always_comb begin
        w_op           = '0;
        w_op.line_mask = NLINES'(1) << i_req.irq_line;
        w_op.code      = i_req.trap_code;
        w_op.bd        = i_req.bd_slot;
        w_op.value     = i_req.current_pc;
        case (t_cmd'(i_req.cmd))
            CMD_SET_LINE:     w_op.set_line = 1'b1;
            CMD_CLR_LINE:     w_op.clr_line = 1'b1;
            CMD_POLL: begin
                // A poll can only enter the interrupt exception, outside a delay slot.
                w_op.poll = 1'b1;
                w_op.code = EXC_INT;
                w_op.bd   = 1'b0;
            end
            CMD_RAISE:        w_op.raise = 1'b1;
            CMD_COP_UNUSABLE: begin
                w_op.cpu  = 1'b1;
                w_op.code = EXC_CPU;
            end
            CMD_ERET:         w_op.eret = 1'b1;
            CMD_WR_STATUS: begin
                w_op.wr_status = 1'b1;
                w_op.value     = i_req.write_data;
            end
            CMD_WR_CAUSE: begin
                w_op.wr_cause = 1'b1;
                w_op.value    = i_req.write_data;
            end
            CMD_WR_EPC: begin
                w_op.wr_epc = 1'b1;
                w_op.value  = i_req.write_data;
            end
            CMD_WR_ERROR_EPC: begin
                w_op.wr_error_epc = 1'b1;
                w_op.value        = i_req.write_data;
            end
            default: ;
        endcase
    end

    assign o_push.valid = i_req.valid && !i_q_full;
    assign o_push.op    = w_op;

endmodule

`default_nettype wire

@@ src/mxiu_queue.sv @@
// ----------------------------------------------------------------------------
// MIPS exception and interrupt unit operation queue
// Two-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mxiu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mxiu_pkg::t_push  i_push,
    input  logic             i_pop,
    output mxiu_pkg::t_q_out o_q
);
    import mxiu_pkg::*;

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_do_pop;

    assign w_do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push.valid, w_do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.op;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_q.op    = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

@@ src/mxiu_back.sv @@
// ----------------------------------------------------------------------------
// MIPS exception and interrupt unit back end
// Holds the coprocessor-0 state, executes operations and registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module mxiu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mxiu_pkg::t_q_out i_q,
    output logic             o_pop,
    mxiu_rsp_if.source       o_rsp
);
    import mxiu_pkg::*;

    logic [REG_W-1:0]  r_status, n_status;
    logic [REG_W-1:0]  r_cause, n_cause;
    logic [XLEN-1:0]   r_epc, n_epc;
    logic [XLEN-1:0]   r_error_epc, n_error_epc;
    logic [NLINES-1:0] r_lines, n_lines;
    logic              r_pending, n_pending;

    logic              r_out_valid;
    logic              r_redirect, n_redirect;
    logic [XLEN-1:0]   r_next_pc, n_next_pc;
    logic              r_ll_clear, n_ll_clear;

    logic              w_advance;
    logic              w_irq_ok;
    logic              w_take;
    logic              w_old_exl;
    logic              w_tlb;
    logic [NLINES-1:0] w_lines_clr;
    logic [XLEN-1:0]   w_vec;
    t_op               w_op;

    assign w_op      = i_q.op;
    assign w_advance = !r_out_valid || o_rsp.ready;
    assign o_pop     = i_q.valid && w_advance;

    assign w_old_exl   = r_status[ST_EXL];
    assign w_tlb       = (w_op.code == EXC_TLBL) || (w_op.code == EXC_TLBS);
    assign w_lines_clr = r_lines & ~w_op.line_mask;
    // The poll copies the request lines into Cause IP before the mask test.
    assign w_irq_ok    = (r_status[ST_ERL:ST_IE] == 3'b001) &&
                         ((r_lines & r_status[ST_IM_HI:ST_IM_LO]) != '0);
    assign w_take      = w_op.raise || w_op.cpu || (w_op.poll && w_irq_ok);

    always_comb begin
        if (r_status[ST_BEV]) begin
            if (w_tlb) begin
                w_vec = w_old_exl ? VEC_BEV_GEN : VEC_BEV_TLB;
            end else if (w_op.code == EXC_INT) begin
                w_vec = r_cause[CA_IV] ? VEC_BEV_INT : VEC_BEV_GEN;
            end else begin
                w_vec = VEC_BEV_GEN;
            end
        end else begin
            if (w_tlb) begin
                w_vec = w_old_exl ? VEC_GEN : VEC_TLB;
            end else if (w_op.code == EXC_INT) begin
                w_vec = r_cause[CA_IV] ? VEC_INT : VEC_GEN;
            end else begin
                w_vec = VEC_GEN;
            end
        end
    end

    always_comb begin
        n_status    = r_status;
        n_cause     = r_cause;
        n_epc       = r_epc;
        n_error_epc = r_error_epc;
        n_lines     = r_lines;
        n_pending   = r_pending;
        n_redirect  = 1'b0;
        n_next_pc   = '0;
        n_ll_clear  = 1'b0;

        if (w_op.set_line) begin
            n_lines = r_lines | w_op.line_mask;
        end
        if (w_op.clr_line) begin
            n_lines = w_lines_clr;
            if (w_lines_clr == '0) begin
                n_pending = 1'b0;
            end
        end
        if (w_op.poll) begin
            n_pending                    = 1'b0;
            n_cause[CA_IP_HI:CA_IP_LO]   = r_lines;
        end
        if (w_op.cpu) begin
            n_cause[CA_CE_HI:CA_CE_LO] = CE_COP1;
        end
        if (w_take) begin
            if (!w_old_exl) begin
                n_epc          = w_op.value;
                n_cause[CA_BD] = w_op.bd;
            end
            n_cause[CA_EXC_HI:CA_EXC_LO] = w_op.code;
            if (w_op.code == EXC_INT) begin
                n_lines = '0;
            end
            n_status[ST_EXL] = 1'b1;
            n_status[ST_ERL] = 1'b0;
            n_pending        = 1'b0;
            n_redirect       = 1'b1;
            n_next_pc        = w_vec;
        end
        if (w_op.eret) begin
            if (r_status[ST_ERL]) begin
                n_status[ST_ERL] = 1'b0;
                n_next_pc        = r_error_epc;
            end else begin
                n_status[ST_EXL] = 1'b0;
                n_next_pc        = r_epc;
            end
            n_redirect = 1'b1;
            n_ll_clear = 1'b1;
        end
        if (w_op.wr_status) begin
            n_status = w_op.value[REG_W-1:0];
        end
        if (w_op.wr_cause) begin
            n_cause = w_op.value[REG_W-1:0];
        end
        if (w_op.wr_epc) begin
            n_epc = w_op.value;
        end
        if (w_op.wr_error_epc) begin
            n_error_epc = w_op.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= STATUS_RST;
            r_cause     <= '0;
            r_epc       <= '0;
            r_error_epc <= '0;
            r_lines     <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_status    <= n_status;
                r_cause     <= n_cause;
                r_epc       <= n_epc;
                r_error_epc <= n_error_epc;
                r_lines     <= n_lines;
                r_pending   <= n_pending;
            end
            if (w_advance) begin
                r_out_valid <= i_q.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_redirect <= n_redirect;
            r_next_pc  <= n_next_pc;
            r_ll_clear <= n_ll_clear;
        end
    end

    // The architectural registers only change on a pop, so they already
    // match the result held in the output register.
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.redirect    = r_redirect;
    assign o_rsp.next_pc     = r_next_pc;
    assign o_rsp.status_now  = r_status;
    assign o_rsp.cause_now   = r_cause;
    assign o_rsp.epc_now     = r_epc;
    assign o_rsp.pending_now = r_pending;
    assign o_rsp.ll_clear    = r_ll_clear;

endmodule

`default_nettype wire

@@ src/mips_exception_interrupt_unit_core.sv @@
// ----------------------------------------------------------------------------
// MIPS exception and interrupt unit
// Coprocessor-0 Status/Cause/EPC/ErrorEPC keeper with interrupt request lines.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while its queue is not full and
// returns exactly one response per request, in order. A request that is
// accepted is decoded by the front end and written into a two-entry queue;
// the back end pops it once its output register is free or being taken,
// updates Status, Cause, EPC, ErrorEPC, the request lines and the pending
// flag, and registers the response. Sustained throughput is one request per
// cycle while the response side takes every response, set by the update
// loop on the coprocessor-0 registers in the back end. The queue lets the
// requester keep going for two requests while the response side is stalled.
// Response fields status_now, cause_now, epc_now and pending_now show the
// registers after that request; next_pc is zero whenever redirect is zero.
`default_nettype none

module mips_exception_interrupt_unit_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mxiu_req_if.sink   i_req,
    mxiu_rsp_if.source o_rsp
);
    import mxiu_pkg::*;

    t_push  w_push;
    t_q_out w_q;
    logic   w_pop;

    // Front end: handshake on the request side and command decode.
    mxiu_front u_front (
        .i_req    (i_req),
        .i_q_full (w_q.full),
        .o_push   (w_push)
    );

    // Decoupling queue between decode and execution.
    mxiu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_q     (w_q)
    );

    // Back end: coprocessor-0 state and the registered response.
    mxiu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

    // An ERET response always carries a redirect.
    a_eret_redirects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ll_clear) |-> o_rsp.redirect)
        else $error("ERET response without redirect");

    // The return address is zero on any response that does not redirect.
    a_no_redirect_zero_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.redirect) |-> (o_rsp.next_pc == '0))
        else $error("Nonzero next_pc without redirect");

    // Every exception entry leaves EXL set and ERL clear.
    a_exc_sets_exl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.redirect && !o_rsp.ll_clear) |->
            (o_rsp.status_now[ST_EXL] && !o_rsp.status_now[ST_ERL]))
        else $error("Exception entry without EXL set and ERL clear");

    // No path in the back end sets the pending flag, so it is low on every response.
    a_pending_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !o_rsp.pending_now)
        else $error("Pending flag left set");

    // No request is accepted while the queue is full.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q.full |-> !w_push.valid)
        else $error("Push into full queue");

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the MIPS exception and interrupt unit
// Drives request commands through the request channel, keeps a cycle-free
// model of Status, Cause, EPC, ErrorEPC and the request lines, and checks
// every response field against it in order, with random stalls on both sides.
// ----------------------------------------------------------------------------

import mxiu_pkg::*;

// One request as it is offered on the request channel.
typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [LINE_W-1:0] irq_line;
    logic [CODE_W-1:0] trap_code;
    logic              bd_slot;
    logic [XLEN-1:0]   current_pc;
    logic [XLEN-1:0]   write_data;
} t_cp0_request;

// One response as it comes back on the response channel.
typedef struct packed {
    logic              redirect;
    logic [XLEN-1:0]   next_pc;
    logic [REG_W-1:0]  status_now;
    logic [REG_W-1:0]  cause_now;
    logic [XLEN-1:0]   epc_now;
    logic              pending_now;
    logic              ll_clear;
} t_cp0_response;

// Keeps its own copy of the coprocessor-0 state, works out the response of
// every accepted request and matches the responses in arrival order.
class t_cp0_tracker;
    logic [REG_W-1:0]  status;
    logic [REG_W-1:0]  cause;
    logic [XLEN-1:0]   epc;
    logic [XLEN-1:0]   error_epc;
    logic [NLINES-1:0] lines;
    logic              pending;
    t_cp0_response     awaited_rsp[$];
    int unsigned       errors;
    int unsigned       requests;
    int unsigned       redirects;
    int unsigned       interrupts;

    function new();
        status     = STATUS_RST;
        cause      = '0;
        epc        = '0;
        error_epc  = '0;
        lines      = '0;
        pending    = 1'b0;
        errors     = 0;
        requests   = 0;
        redirects  = 0;
        interrupts = 0;
    endfunction

    // Exception entry; returns the vector.
    function logic [XLEN-1:0] enter_exception(logic [CODE_W-1:0] code, logic bd,
                                              logic [XLEN-1:0] pc);
        logic            old_exl;
        logic            tlb;
        logic            iv;
        logic [XLEN-1:0] vec;
        old_exl = status[ST_EXL];
        tlb     = (code == EXC_TLBL) || (code == EXC_TLBS);
        // EPC and BD are kept while a handler is already running.
        if (!old_exl) begin
            epc         = pc;
            cause[CA_BD] = bd;
        end
        cause[CA_EXC_HI:CA_EXC_LO] = code;
        if (code == EXC_INT) begin
            lines = '0;
        end
        status[ST_EXL] = 1'b1;
        status[ST_ERL] = 1'b0;
        iv = cause[CA_IV];
        if (status[ST_BEV]) begin
            if (tlb) vec = old_exl ? VEC_BEV_GEN : VEC_BEV_TLB;
            else if (code == EXC_INT) vec = iv ? VEC_BEV_INT : VEC_BEV_GEN;
            else vec = VEC_BEV_GEN;
        end else begin
            if (tlb) vec = old_exl ? VEC_GEN : VEC_TLB;
            else if (code == EXC_INT) vec = iv ? VEC_INT : VEC_GEN;
            else vec = VEC_GEN;
        end
        pending = 1'b0;
        return vec;
    endfunction

    function void note_request(t_cp0_request r);
        t_cp0_response e;
        e = '0;
        requests++;
        case (r.cmd)
            CMD_SET_LINE: lines[r.irq_line] = 1'b1;
            CMD_CLR_LINE: begin
                lines[r.irq_line] = 1'b0;
                if (lines == '0) pending = 1'b0;
            end
            CMD_POLL: begin
                pending = 1'b0;
                cause[CA_IP_HI:CA_IP_LO] = lines;
                if (status[ST_IE] && !status[ST_EXL] && !status[ST_ERL] &&
                    (cause[CA_IP_HI:CA_IP_LO] & status[ST_IM_HI:ST_IM_LO]) != '0) begin
                    pending    = 1'b1;
                    e.next_pc  = enter_exception(EXC_INT, 1'b0, r.current_pc);
                    e.redirect = 1'b1;
                    interrupts++;
                end
            end
            CMD_RAISE: begin
                e.next_pc  = enter_exception(r.trap_code, r.bd_slot, r.current_pc);
                e.redirect = 1'b1;
            end
            CMD_COP_UNUSABLE: begin
                cause[CA_CE_HI:CA_CE_LO] = CE_COP1;
                e.next_pc  = enter_exception(EXC_CPU, r.bd_slot, r.current_pc);
                e.redirect = 1'b1;
            end
            CMD_ERET: begin
                if (status[ST_ERL]) begin
                    status[ST_ERL] = 1'b0;
                    e.next_pc = error_epc;
                end else begin
                    status[ST_EXL] = 1'b0;
                    e.next_pc = epc;
                end
                e.redirect = 1'b1;
                e.ll_clear = 1'b1;
            end
            CMD_WR_STATUS:    status    = r.write_data[REG_W-1:0];
            CMD_WR_CAUSE:     cause     = r.write_data[REG_W-1:0];
            CMD_WR_EPC:       epc       = r.write_data;
            CMD_WR_ERROR_EPC: error_epc = r.write_data;
            default: ;
        endcase
        if (e.redirect) redirects++;
        e.status_now  = status;
        e.cause_now   = cause;
        e.epc_now     = epc;
        e.pending_now = pending;
        awaited_rsp.push_back(e);
    endfunction

    function void match(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    function void check_response(t_cp0_response got);
        t_cp0_response want;
        if (awaited_rsp.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
        end
        want = awaited_rsp.pop_front();
        match("redirect", XLEN'(want.redirect), XLEN'(got.redirect));
        match("next_pc", want.next_pc, got.next_pc);
        match("status_now", XLEN'(want.status_now), XLEN'(got.status_now));
        match("cause_now", XLEN'(want.cause_now), XLEN'(got.cause_now));
        match("epc_now", want.epc_now, got.epc_now);
        match("pending_now", XLEN'(want.pending_now), XLEN'(got.pending_now));
        match("ll_clear", XLEN'(want.ll_clear), XLEN'(got.ll_clear));
    endfunction

    function int unsigned outstanding();
        return awaited_rsp.size();
    endfunction
endclass

module tb;

    // First command code that the unit ignores.
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(int'(CMD_WR_ERROR_EPC) + 1);
    localparam logic [CMD_W-1:0] CMD_LAST_CODE    = {CMD_W{1'b1}};
    localparam int RANDOM_ITEMS   = 1700;
    localparam int GAP_PCT        = 32;
    localparam int HOLD_CYCLES    = 80;
    localparam int HOLD_AT        = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    // Status with IE set, EXL and ERL clear, all IM bits enabled.
    localparam logic [XLEN-1:0] ST_IRQ_ON  = 64'h0000_0000_0040_ff01;
    localparam logic [XLEN-1:0] ST_IRQ_NBV = 64'h0000_0000_0000_ff01;

    logic i_clk;
    logic i_rst_n;

    mxiu_req_if req();
    mxiu_rsp_if rsp();

    mips_exception_interrupt_unit_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    t_cp0_tracker book;

    // Both sides insert random gaps while this is set. The random phase
    // clears it for a stretch so back-to-back traffic is covered as well.
    bit gaps_on = 1'b1;
    int unsigned sent = 0;
    int unsigned idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Requests are driven with nonblocking assignments at the rising edge;
    // acceptance is judged from the values seen at that edge.
    task automatic send_request(input t_cp0_request r);
        while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid      <= 1'b1;
        req.cmd        <= r.cmd;
        req.irq_line   <= r.irq_line;
        req.trap_code  <= r.trap_code;
        req.bd_slot    <= r.bd_slot;
        req.current_pc <= r.current_pc;
        req.write_data <= r.write_data;
        do @(posedge i_clk); while (!req.ready);
        book.note_request(r);
        sent++;
    endtask

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [LINE_W-1:0] line,
                        input logic [CODE_W-1:0] code, input logic bd,
                        input logic [XLEN-1:0] pc, input logic [XLEN-1:0] data);
        t_cp0_request r;
        r.cmd        = cmd;
        r.irq_line   = line;
        r.trap_code  = code;
        r.bd_slot    = bd;
        r.current_pc = pc;
        r.write_data = data;
        send_request(r);
    endtask

    function automatic logic [XLEN-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random request mix shaped like real traffic: lines come and go, the
    // handler gets entered by polls and raises and left by ERET, and Status
    // is mostly written with interrupts enabled so that polls actually fire.
    function automatic t_cp0_request random_request();
        t_cp0_request r;
        int unsigned  pick;
        r.irq_line   = LINE_W'($urandom_range(0, NLINES - 1));
        r.trap_code  = CODE_W'($urandom_range(0, 31));
        r.bd_slot    = 1'($urandom_range(0, 1));
        r.current_pc = rand64();
        r.write_data = rand64();
        pick = $urandom_range(0, 99);
        if (pick < 16)      r.cmd = CMD_SET_LINE;
        else if (pick < 26) r.cmd = CMD_CLR_LINE;
        else if (pick < 46) r.cmd = CMD_POLL;
        else if (pick < 56) r.cmd = CMD_RAISE;
        else if (pick < 62) r.cmd = CMD_COP_UNUSABLE;
        else if (pick < 77) r.cmd = CMD_ERET;
        else if (pick < 87) r.cmd = CMD_WR_STATUS;
        else if (pick < 92) r.cmd = CMD_WR_CAUSE;
        else if (pick < 95) r.cmd = CMD_WR_EPC;
        else if (pick < 98) r.cmd = CMD_WR_ERROR_EPC;
        else r.cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
        // TLB codes get their share so both refill vectors are hit often.
        if (r.cmd == CMD_RAISE && $urandom_range(0, 2) == 0) begin
            r.trap_code = CODE_W'($urandom_range(EXC_TLBL, EXC_TLBS));
        end
        if (r.cmd == CMD_WR_STATUS && $urandom_range(0, 99) < 65) begin
            r.write_data[ST_ERL:ST_IE] = 3'b001;
        end
        return r;
    endfunction

    // Response side: random back-pressure, plus one long hold-off once the
    // traffic is under way, so that the internal queue fills and the
    // request channel has to stall.
    initial begin : response_side
        int  hold_left;
        bit  hold_done;
        bit  take;
        t_cp0_response got;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (!hold_done && sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                take = 1'b0;
            end else begin
                take = !gaps_on || ($urandom_range(0, 99) >= GAP_PCT);
            end
            rsp.ready <= take;
            @(posedge i_clk);
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
                got.redirect    = rsp.redirect;
                got.next_pc     = rsp.next_pc;
                got.status_now  = rsp.status_now;
                got.cause_now   = rsp.cause_now;
                got.epc_now     = rsp.epc_now;
                got.pending_now = rsp.pending_now;
                got.ll_clear    = rsp.ll_clear;
                book.check_response(got);
            end
        end
    end

    // Watchdog: any cycle with a handshake on either side restarts the count.
    always @(posedge i_clk) begin
        if ((req.valid === 1'b1 && req.ready === 1'b1) ||
            (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        book = new();
        i_rst_n        <= 1'b0;
        req.valid      <= 1'b0;
        req.cmd        <= CMD_POLL;
        req.irq_line   <= '0;
        req.trap_code  <= '0;
        req.bd_slot    <= 1'b0;
        req.current_pc <= '0;
        req.write_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Out of reset BEV is set and interrupts are off.
        send(CMD_POLL, 0, 0, 0, 64'h1000, 0);                  // nothing taken
        send(CMD_SET_LINE, 0, 0, 0, 0, 0);
        send(CMD_SET_LINE, 7, 0, 0, 0, 0);
        send(CMD_WR_STATUS, 0, 0, 0, 0, ST_IRQ_ON);
        send(CMD_POLL, 0, 0, 1, 64'h2000, 0);                  // interrupt, IV clear
        send(CMD_ERET, 0, 0, 0, 0, 0);                         // back to EPC
        send(CMD_WR_CAUSE, 0, 0, 0, 0, 64'h0080_0000);         // IV set
        send(CMD_SET_LINE, 3, 0, 0, 0, 0);
        send(CMD_POLL, 0, 0, 0, 64'h3000, 0);                  // interrupt, IV set
        send(CMD_ERET, 0, 0, 0, 0, 0);
        send(CMD_RAISE, 0, EXC_TLBL, 1, 64'h4000, 0);          // refill, EXL was clear
        send(CMD_RAISE, 0, EXC_TLBS, 0, 64'h5000, 0);          // refill, EXL was set
        send(CMD_WR_ERROR_EPC, 0, 0, 0, 0, {XLEN{1'b1}});
        send(CMD_WR_STATUS, 0, 0, 0, 0, 64'hffff_ffff_ffbf_fffe);  // ERL set, BEV clear
        send(CMD_ERET, 0, 0, 0, 0, 0);                         // returns to ErrorEPC
        send(CMD_WR_STATUS, 0, 0, 0, 0, ST_IRQ_NBV);
        send(CMD_RAISE, 0, EXC_TLBS, 0, {XLEN{1'b1}}, 0);      // normal refill vector
        send(CMD_COP_UNUSABLE, 0, 0, 1, 64'h6000, 0);          // EXL set, EPC kept
        send(CMD_WR_EPC, 0, 0, 0, 0, {XLEN{1'b1}});
        send(CMD_ERET, 0, 0, 0, 0, 0);
        send(CMD_SET_LINE, 5, 0, 0, 0, 0);
        send(CMD_POLL, 0, 0, 0, 64'h7000, 0);                  // interrupt, BEV clear, IV set
        send(CMD_WR_CAUSE, 0, 0, 0, 0, 64'h0);
        send(CMD_ERET, 0, 0, 0, 0, 0);
        send(CMD_RAISE, 0, 5'd31, 1, 64'h8000, 0);             // general exception
        send(CMD_CLR_LINE, 5, 0, 0, 0, 0);                     // lines empty again
        send(CMD_LAST_CODE, 0, 0, 0, 0, 0);                    // ignored command

        // Random part, with a stretch of uninterrupted traffic in the middle.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            gaps_on = !(i >= 800 && i < 1100);
            send_request(random_request());
        end
        req.valid <= 1'b0;
        gaps_on = 1'b1;

        while (book.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("tb: %0d requests, %0d redirects of which %0d polled interrupts",
                 book.requests, book.redirects, book.interrupts);
        $display("tb: covered both vector sets, refill, ERET via EXL and ERL, stalls");
        if (book.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/mxiu_pkg.sv
src/mxiu_if.sv
src/mxiu_front.sv
src/mxiu_queue.sv
src/mxiu_back.sv
src/mips_exception_interrupt_unit_core.sv
test/tb.sv
